// ===== sv/imu_sfd_pkg.sv =====
// Shared types, constants and gain table for the IMU serial frame decoder.
package imu_sfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 4;
    localparam int WORD_W  = 16;
    localparam int MAG_W   = WORD_W + 1;
    localparam int GAIN_W  = 25;
    localparam int VAL_W   = 25;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = MAG_W + GAIN_W;
    localparam int AXES    = 3;
    localparam int PAY_N   = 2 * AXES;
    localparam int PAY_IDX_W = $clog2(PAY_N);

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] TYPE_ACC = 8'h51;
    localparam logic [BYTE_W-1:0] TYPE_GYR = 8'h52;
    localparam logic [BYTE_W-1:0] TYPE_ANG = 8'h53;

    // byte positions inside a frame
    localparam logic [POS_W-1:0] POS_HUNT     = 4'd0;
    localparam logic [POS_W-1:0] POS_TYPE     = 4'd1;
    localparam logic [POS_W-1:0] POS_PAY_FIRST = 4'd2;
    localparam logic [POS_W-1:0] POS_PAY_LAST = 4'd7;
    localparam logic [POS_W-1:0] POS_CSUM     = 4'd10;

    // Q9.16 gains: 16 g, 2000 deg/s and pi rad full scale over 32768
    localparam logic [GAIN_W-1:0] K_ACC = 25'd20566036;
    localparam logic [GAIN_W-1:0] K_GYR = 25'd4575276;
    localparam logic [GAIN_W-1:0] K_ANG = 25'd411775;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_CSUM = 2'd1,
        ST_TYPE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_ACC = 2'd0,
        KIND_GYR = 2'd1,
        KIND_ANG = 2'd2
    } kind_t;

    // decoded frame handed from the parser to the scaling stage
    typedef struct packed {
        status_t                     status;
        kind_t                       kind;
        logic [AXES-1:0]             neg;
        logic [AXES-1:0][MAG_W-1:0]  mag;
    } frame_t;

    function automatic logic [GAIN_W-1:0] kind_gain(input kind_t kind);
        logic [GAIN_W-1:0] g;
        case (kind)
            KIND_ACC: g = K_ACC;
            KIND_GYR: g = K_GYR;
            KIND_ANG: g = K_ANG;
            default:  g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== sv/imu_sfd_parser.sv =====
// Byte-level frame parser: header hunt, checksum, type decode, frame register.
module imu_sfd_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_accept,
    input  logic [imu_sfd_pkg::BYTE_W-1:0] rx_byte,
    input  logic                           advance,
    output logic                           frm_valid,
    output imu_sfd_pkg::frame_t            frm
);

    logic [imu_sfd_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [imu_sfd_pkg::BYTE_W-1:0] sum_reg, sum_next;
    logic [imu_sfd_pkg::BYTE_W-1:0] type_reg, type_next;
    logic [imu_sfd_pkg::BYTE_W-1:0] pay_reg [imu_sfd_pkg::PAY_N];
    logic                           frm_valid_reg, frm_valid_next;
    imu_sfd_pkg::frame_t            frm_reg, frm_next;

    logic                                hunting;
    logic                                done;
    logic                                pay_wr;
    logic [imu_sfd_pkg::PAY_IDX_W-1:0]   pay_idx;
    logic [imu_sfd_pkg::POS_W-1:0]       pay_off;
    logic [imu_sfd_pkg::WORD_W-1:0]      word [imu_sfd_pkg::AXES];

    assign hunting = (pos_reg == imu_sfd_pkg::POS_HUNT) || (pos_reg > imu_sfd_pkg::POS_CSUM);
    assign done    = byte_accept && !hunting && (pos_reg == imu_sfd_pkg::POS_CSUM);
    assign pay_off = pos_reg - imu_sfd_pkg::POS_PAY_FIRST;
    assign pay_idx = pay_off[imu_sfd_pkg::PAY_IDX_W-1:0];
    assign pay_wr  = byte_accept && !hunting
                     && (pos_reg >= imu_sfd_pkg::POS_PAY_FIRST)
                     && (pos_reg <= imu_sfd_pkg::POS_PAY_LAST);

    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        type_next = type_reg;
        if (byte_accept)
        begin
            if (hunting)
            begin
                if (rx_byte == imu_sfd_pkg::HDR_BYTE)
                begin
                    sum_next = imu_sfd_pkg::HDR_BYTE;
                    pos_next = imu_sfd_pkg::POS_TYPE;
                end
                else
                begin
                    pos_next = imu_sfd_pkg::POS_HUNT;
                end
            end
            else if (pos_reg < imu_sfd_pkg::POS_CSUM)
            begin
                if (pos_reg == imu_sfd_pkg::POS_TYPE)
                begin
                    type_next = rx_byte;
                end
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + 4'd1;
            end
            else
            begin
                pos_next = imu_sfd_pkg::POS_HUNT;
            end
        end
    end

    // little-endian words from the stored data bytes
    always_comb
    begin
        for (int i = 0; i < imu_sfd_pkg::AXES; i++)
        begin
            word[i] = {pay_reg[2*i+1], pay_reg[2*i]};
        end
    end

    always_comb
    begin
        frm_next        = frm_reg;
        frm_next.status = imu_sfd_pkg::ST_OK;
        frm_next.kind   = imu_sfd_pkg::KIND_ACC;
        if (sum_reg != rx_byte)
        begin
            frm_next.status = imu_sfd_pkg::ST_CSUM;
        end
        else
        begin
            case (type_reg)
                imu_sfd_pkg::TYPE_ACC: frm_next.kind = imu_sfd_pkg::KIND_ACC;
                imu_sfd_pkg::TYPE_GYR: frm_next.kind = imu_sfd_pkg::KIND_GYR;
                imu_sfd_pkg::TYPE_ANG: frm_next.kind = imu_sfd_pkg::KIND_ANG;
                default:               frm_next.status = imu_sfd_pkg::ST_TYPE;
            endcase
        end
        for (int i = 0; i < imu_sfd_pkg::AXES; i++)
        begin
            if (frm_next.status == imu_sfd_pkg::ST_OK)
            begin
                frm_next.neg[i] = word[i][imu_sfd_pkg::WORD_W-1];
                frm_next.mag[i] = word[i][imu_sfd_pkg::WORD_W-1]
                    ? imu_sfd_pkg::MAG_W'(17'h10000 - {1'b0, word[i]})
                    : {1'b0, word[i]};
            end
            else
            begin
                // error results carry zero values
                frm_next.neg[i] = 1'b0;
                frm_next.mag[i] = '0;
            end
        end
    end

    // a new frame only lands when the slot is free or draining this cycle
    assign frm_valid_next = (frm_valid_reg && !advance) || done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= imu_sfd_pkg::POS_HUNT;
            sum_reg       <= '0;
            type_reg      <= '0;
            frm_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            type_reg      <= type_next;
            frm_valid_reg <= frm_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_wr)
        begin
            pay_reg[pay_idx] <= rx_byte;
        end
        if (done)
        begin
            frm_reg <= frm_next;
        end
    end

    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

endmodule

// ===== sv/imu_sfd_scale.sv =====
// One axis of the scaling to signed Q8.16: magnitude times gain, round half away, sign.
module imu_sfd_scale (
    input  logic                                  neg,
    input  logic [imu_sfd_pkg::MAG_W-1:0]         mag,
    input  logic [imu_sfd_pkg::GAIN_W-1:0]        gain,
    output logic signed [imu_sfd_pkg::VAL_W-1:0]  value
);

    logic [imu_sfd_pkg::PROD_W-1:0] prod;
    logic [imu_sfd_pkg::PROD_W-1:0] rounded;
    logic [imu_sfd_pkg::VAL_W-1:0]  q;

    assign prod    = imu_sfd_pkg::PROD_W'(mag) * imu_sfd_pkg::PROD_W'(gain);
    assign rounded = (prod + imu_sfd_pkg::ROUND_HALF) >> imu_sfd_pkg::FRAC_W;
    assign q       = rounded[imu_sfd_pkg::VAL_W-1:0];
    assign value   = neg ? (~q + 1'b1) : q;

endmodule

// ===== sv/imu_serial_frame_decoder_unit.sv =====
// Top level of the IMU serial frame decoder: parser, scaling lanes, output register.
//
// Input stream (s_*): one received serial byte per item in s_tdata[7:0].
// Bytes other than 0x55 are dropped while hunting; after a header, ten more
// bytes (type, eight data bytes, checksum) complete a frame. The checksum
// byte produces exactly one result item; all other bytes produce none.
// Output stream (m_*): m_tuser carries status and kind, m_tdata the three
// signed Q8.16 axis values. Errors (checksum mismatch, unknown type) give
// kind 0 and zero values.
// Result path: the frame register loads on the edge that accepts the checksum
// byte; the output register loads from it when it is empty or being read, and
// m_tvalid is driven from the output register.
// Throughput: one byte per cycle while s_tready is high, set by the parser update and
// one 17x25 multiply per axis between the frame and output registers.
// When m_tready is low the result holds in the output register, one further
// frame can wait in the frame register, and bytes keep flowing until that
// frame register is full; then s_tready drops.
// Reset (rst_n low, asynchronous) returns the parser to header hunting and
// empties both stages.
module imu_serial_frame_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [24:0] value_x, [49:25] value_y, [74:50] value_z, pad
    output logic [3:0]  m_tuser    // [1:0] status, [3:2] kind
);

    logic                byte_accept;
    logic                advance;
    logic                frm_valid;
    imu_sfd_pkg::frame_t frm;
    logic [imu_sfd_pkg::GAIN_W-1:0]        gain;
    logic signed [imu_sfd_pkg::VAL_W-1:0]  lane_val [imu_sfd_pkg::AXES];

    logic                                  out_valid_reg, out_valid_next;
    imu_sfd_pkg::status_t                  status_reg;
    imu_sfd_pkg::kind_t                    kind_reg;
    logic signed [imu_sfd_pkg::VAL_W-1:0]  val_reg [imu_sfd_pkg::AXES];

    assign advance     = !out_valid_reg || m_tready;
    assign s_tready    = !frm_valid || advance;
    assign byte_accept = s_tvalid && s_tready;

    imu_sfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .advance     (advance),
        .frm_valid   (frm_valid),
        .frm         (frm)
    );

    assign gain = imu_sfd_pkg::kind_gain(frm.kind);

    genvar g;
    generate
        for (g = 0; g < imu_sfd_pkg::AXES; g++)
        begin : g_lane
            imu_sfd_scale u_scale (
                .neg   (frm.neg[g]),
                .mag   (frm.mag[g]),
                .gain  (gain),
                .value (lane_val[g])
            );
        end
    endgenerate

    assign out_valid_next = advance ? frm_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && frm_valid)
        begin
            status_reg <= frm.status;
            kind_reg   <= frm.kind;
            for (int i = 0; i < imu_sfd_pkg::AXES; i++)
            begin
                val_reg[i] <= lane_val[i];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {kind_reg, status_reg};
    assign m_tdata  = {5'd0, val_reg[2], val_reg[1], val_reg[0]};

endmodule

// ===== sv/imu_sfd_checker.sv =====
// Port-level checker for the IMU serial frame decoder, bound to the top level.
module imu_sfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [3:0]  m_tuser
);

    logic [1:0] st;
    logic [1:0] kd;

    assign st = m_tuser[1:0];
    assign kd = m_tuser[3:2];

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (st == imu_sfd_pkg::ST_OK || st == imu_sfd_pkg::ST_CSUM
                      || st == imu_sfd_pkg::ST_TYPE)
                     && (kd == imu_sfd_pkg::KIND_ACC || kd == imu_sfd_pkg::KIND_GYR
                         || kd == imu_sfd_pkg::KIND_ANG))
        else $error("status or kind out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st != imu_sfd_pkg::ST_OK)
        |-> (kd == imu_sfd_pkg::KIND_ACC) && (m_tdata == '0))
        else $error("error result carries data");

    // a fresh result follows an accepted byte, through the frame and output registers
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding byte");

endmodule

bind imu_serial_frame_decoder_unit imu_sfd_checker u_imu_sfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_imu_serial_frame_decoder_unit.sv =====
// Self-checking testbench for the IMU serial frame decoder: directed and random byte streams.
module tb_imu_serial_frame_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned GAIN_ACC_Q16 = 64'd20566036;
    localparam longint unsigned GAIN_GYR_Q16 = 64'd4575276;
    localparam longint unsigned GAIN_ANG_Q16 = 64'd411775;
    localparam logic [3:0] LAST_POS     = 4'd10;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         RANDOM_BYTES = 470;

    typedef struct {
        imu_sfd_pkg::status_t status;
        imu_sfd_pkg::kind_t   kind;
        logic [24:0]          vx;
        logic [24:0]          vy;
        logic [24:0]          vz;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;    // [24:0] value_x, [49:25] value_y, [74:50] value_z, pad
    logic [3:0]  m_tuser;    // [1:0] status, [3:2] kind

    // decoder state mirrored by the predictor
    logic [3:0]  frame_pos;
    logic [7:0]  frame_sum;
    logic [7:0]  frame_type_byte;
    logic [7:0]  frame_data [6];

    reading_t    expected_readings [$];
    int          error_count;
    int          stalled_cycles;
    int          bytes_sent;
    bit          no_idle;

    imu_serial_frame_decoder_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // round(word * gain / 2^16), ties away from zero, on the magnitude
    function automatic logic [24:0] scale_axis(input logic [15:0] word,
                                               input longint unsigned gain);
        longint unsigned mag;
        longint unsigned q;
        mag = word[15] ? (64'h10000 - 64'(word)) : 64'(word);
        q = (mag * gain + 64'd32768) >> 16;
        if (word[15])
            q = -q;
        return q[24:0];
    endfunction

    task automatic track_byte(input logic [7:0] rx);
        reading_t        r;
        longint unsigned gain;
        if (frame_pos == 4'd0 || frame_pos > LAST_POS)
        begin
            if (rx == imu_sfd_pkg::HDR_BYTE)
            begin
                frame_sum = imu_sfd_pkg::HDR_BYTE;
                frame_pos = 4'd1;
            end
            else
                frame_pos = 4'd0;
        end
        else if (frame_pos < LAST_POS)
        begin
            if (frame_pos == 4'd1)
                frame_type_byte = rx;
            else if (frame_pos <= 4'd7)
                frame_data[3'(frame_pos - 4'd2)] = rx;
            frame_sum = frame_sum + rx;
            frame_pos = frame_pos + 4'd1;
        end
        else
        begin
            frame_pos = 4'd0;
            r.status = imu_sfd_pkg::ST_OK;
            r.kind = imu_sfd_pkg::KIND_ACC;
            gain = 0;
            if (frame_sum != rx)
                r.status = imu_sfd_pkg::ST_CSUM;
            else
                case (frame_type_byte)
                    imu_sfd_pkg::TYPE_ACC:
                    begin
                        r.kind = imu_sfd_pkg::KIND_ACC;
                        gain = GAIN_ACC_Q16;
                    end
                    imu_sfd_pkg::TYPE_GYR:
                    begin
                        r.kind = imu_sfd_pkg::KIND_GYR;
                        gain = GAIN_GYR_Q16;
                    end
                    imu_sfd_pkg::TYPE_ANG:
                    begin
                        r.kind = imu_sfd_pkg::KIND_ANG;
                        gain = GAIN_ANG_Q16;
                    end
                    default: r.status = imu_sfd_pkg::ST_TYPE;
                endcase
            if (r.status == imu_sfd_pkg::ST_OK)
            begin
                r.vx = scale_axis({frame_data[1], frame_data[0]}, gain);
                r.vy = scale_axis({frame_data[3], frame_data[2]}, gain);
                r.vz = scale_axis({frame_data[5], frame_data[4]}, gain);
            end
            else
            begin
                r.vx = '0;
                r.vy = '0;
                r.vz = '0;
            end
            expected_readings.push_back(r);
        end
    endtask

    // drive one byte, after an optional random idle gap, and hold it until the block takes it
    task automatic send_byte(input logic [7:0] rx);
        int gap;
        if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        track_byte(rx);
        bytes_sent++;
    endtask

    // csum_err is XORed into the correct checksum; zero gives a good frame
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] wx,
                              input logic [15:0] wy, input logic [15:0] wz,
                              input logic [7:0] tail_a, input logic [7:0] tail_b,
                              input logic [7:0] csum_err);
        logic [7:0] fb [11];
        logic [7:0] sum;
        fb[0] = imu_sfd_pkg::HDR_BYTE;
        fb[1] = ftype;
        fb[2] = wx[7:0];
        fb[3] = wx[15:8];
        fb[4] = wy[7:0];
        fb[5] = wy[15:8];
        fb[6] = wz[7:0];
        fb[7] = wz[15:8];
        fb[8] = tail_a;
        fb[9] = tail_b;
        sum = 8'd0;
        for (int i = 0; i < 10; i++)
            sum = sum + fb[i];
        fb[10] = sum ^ csum_err;
        for (int i = 0; i < 11; i++)
            send_byte(fb[i]);
    endtask

    task automatic wait_for_readings();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:  return imu_sfd_pkg::TYPE_ACC;
            6, 7, 8, 9, 10:    return imu_sfd_pkg::TYPE_GYR;
            11, 12, 13, 14, 15: return imu_sfd_pkg::TYPE_ANG;
            default:           return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_frame(input int bad_pct);
        logic [7:0] err;
        err = ($urandom_range(0, 99) < bad_pct) ? 8'($urandom_range(1, 255)) : 8'h00;
        send_frame(pick_type(), pick_word(), pick_word(), pick_word(),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), err);
    endtask

    // noise while hunting, then one frame of each kind at the word extremes
    task automatic test_hunt_and_kinds();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h54);
        send_byte(8'hAA);
        send_frame(imu_sfd_pkg::TYPE_ACC, 16'h8000, 16'h7FFF, 16'h0000,
                   8'h00, 8'h00, 8'h00);
        send_frame(imu_sfd_pkg::TYPE_GYR, 16'hFFFF, 16'h0001, 16'h8000,
                   8'hFF, 8'hFF, 8'h00);
        send_frame(imu_sfd_pkg::TYPE_ANG, 16'h7FFF, 16'h8000, 16'hFFFF,
                   8'hA5, 8'h5A, 8'h00);
    endtask

    task automatic test_error_frames();
        send_frame(imu_sfd_pkg::TYPE_ACC, 16'h1234, 16'h5678, 16'h9ABC,
                   8'h11, 8'h22, 8'h01);
        // checksum failure wins over an unknown type
        send_frame(8'hFF, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h80);
        send_frame(8'h00, 16'h7FFF, 16'h8000, 16'h0001, 8'h00, 8'h00, 8'h00);
        // header bytes inside a frame are plain data
        send_frame(imu_sfd_pkg::HDR_BYTE, 16'h5555, 16'h0055, 16'h5500,
                   8'h55, 8'h55, 8'h00);
        send_frame(imu_sfd_pkg::TYPE_GYR, 16'h5555, 16'h5555, 16'h5555,
                   8'h55, 8'h55, 8'h00);
    endtask

    // mostly good frames with random content, some noise and cut-short frames
    task automatic test_random_stream(input int n_bytes);
        int stop_at;
        int n_partial;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            case ($urandom_range(0, 19))
                0, 1:
                    send_byte(8'($urandom_range(0, 255)));
                2:
                begin
                    n_partial = $urandom_range(1, 9);
                    send_byte(imu_sfd_pkg::HDR_BYTE);
                    repeat (n_partial) send_byte(8'($urandom_range(0, 255)));
                end
                default:
                    send_random_frame(10);
            endcase
        end
    endtask

    task automatic test_drain_pause();
        wait_for_readings();
        send_random_frame(0);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (10) send_random_frame(10);
    endtask

    always @(posedge clk)
    begin : check_reading
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("unexpected result: status %0d kind %0d", m_tuser[1:0], m_tuser[3:2]);
                error_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (m_tuser[1:0] != want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[1:0]);
                    error_count++;
                end
                if (m_tuser[3:2] != want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser[3:2]);
                    error_count++;
                end
                if (m_tdata[24:0] != want.vx)
                begin
                    $error("value_x: expected %0d, got %0d",
                           $signed(want.vx), $signed(m_tdata[24:0]));
                    error_count++;
                end
                if (m_tdata[49:25] != want.vy)
                begin
                    $error("value_y: expected %0d, got %0d",
                           $signed(want.vy), $signed(m_tdata[49:25]));
                    error_count++;
                end
                if (m_tdata[74:50] != want.vz)
                begin
                    $error("value_z: expected %0d, got %0d",
                           $signed(want.vz), $signed(m_tdata[74:50]));
                    error_count++;
                end
            end
        end
    end

    // receiver back-pressure in random bursts, always ready while no_idle is set
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (no_idle)
                m_tready <= 1'b1;
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles = 0;
        else
            stalled_cycles = stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        no_idle = 1'b0;
        error_count = 0;
        stalled_cycles = 0;
        bytes_sent = 0;
        frame_pos = 4'd0;
        frame_sum = 8'h00;
        frame_type_byte = 8'h00;
        for (int i = 0; i < 6; i++)
            frame_data[i] = 8'h00;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_hunt_and_kinds();
        test_error_frames();
        test_random_stream(RANDOM_BYTES);
        test_drain_pause();
        test_random_stream(RANDOM_BYTES);
        test_back_to_back();

        wait_for_readings();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/imu_sfd_pkg.sv
sv/imu_sfd_parser.sv
sv/imu_sfd_scale.sv
sv/imu_serial_frame_decoder_unit.sv
sv/imu_sfd_checker.sv
tb/tb_imu_serial_frame_decoder_unit.sv
